[design/twbt_pkg.sv]
package twbt_pkg;

   localparam int TIME_BITS  = 27;
   localparam int PRICE_BITS = 24;
   localparam int INSTR_BITS = 32;
   localparam int WSEC_BITS  = 12;
   localparam int LIMIT_W    = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_WINDOW_DEPTH = 64;

   localparam logic [LIMIT_W-1:0] MS_PER_SEC = LIMIT_W'(1000);

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_REARM = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_INSTRUMENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER    = 2'd2;

   localparam logic [INSTR_BITS-1:0] RST_INSTRUMENT = '0;
   localparam logic [WSEC_BITS-1:0]  RST_WINDOW     = WSEC_BITS'(60);
   localparam logic [PRICE_BITS-1:0] RST_TRIGGER    = PRICE_BITS'(100);

   typedef struct packed {
      logic                  op;
      logic [INSTR_BITS-1:0] tick_instrument;
      logic [TIME_BITS-1:0]  tick_time_ms;
      logic [PRICE_BITS-1:0] last_price;
   } req_type;

   typedef struct packed {
      logic                  order_fire;
      logic                  order_is_sell;
      logic [PRICE_BITS-1:0] order_price;
      logic                  window_dropped;
   } rsp_type;

endpackage

[design/twbt_ram.sv]
module twbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/time_window_breakout_trigger.sv]
// sequence: a rearm or a foreign tick goes straight to the result; otherwise evict and search
//   over the window reads, place the tick (no shift on an overwrite), shift the newer entries up,
//   scan the entries after insertion (none while latched), and load the result
// one transaction at a time over the window ram with one read and one write port, the next one
//   taken the cycle after the result is loaded; reset: synchronous, empty window, no order latched
module time_window_breakout_trigger #(
   parameter int WINDOW_DEPTH = twbt_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  twbt_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output twbt_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [twbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twbt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import twbt_pkg::*;

   localparam int IDX_W   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int ENTRY_W = TIME_BITS + PRICE_BITS;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FIND   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_PREP   = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p);
      return (p == '0) ? LAST_IDX : p - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[IDX_W-1:0];
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [INSTR_BITS-1:0] inst_ff, inst_in;
   logic [WSEC_BITS-1:0]  wsec_ff, wsec_in;
   logic [PRICE_BITS-1:0] delta_ff, delta_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  latched_ff, latched_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]      iss_addr_ff, iss_addr_in;
   logic                  dat_vld_ff, dat_vld_in;
   logic [IDX_W-1:0]      dat_addr_ff, dat_addr_in;
   logic                  evict_ff, evict_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic                  match_ff, match_in;
   logic [IDX_W-1:0]      match_addr_ff, match_addr_in;
   logic [IDX_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PRICE_BITS-1:0] low_ff, low_in;
   logic [PRICE_BITS-1:0] high_ff, high_in;
   logic                  res_fire_ff, res_fire_in;
   logic                  res_sell_ff, res_sell_in;
   logic                  res_drop_ff, res_drop_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  rd_issue;
   logic                  step_done;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [ENTRY_W-1:0]    ram_rd_data;

   logic [TIME_BITS-1:0]  rd_time;
   logic [PRICE_BITS-1:0] rd_price;
   logic [TIME_BITS:0]    age;
   logic                  too_old;
   logic [PRICE_BITS:0]   diff_low;
   logic [PRICE_BITS:0]   diff_high;
   logic                  fire_buy;
   logic                  fire_sell;

   twbt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (iss_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign rd_time  = ram_rd_data[ENTRY_W-1:PRICE_BITS];
   assign rd_price = ram_rd_data[PRICE_BITS-1:0];

   // signed age, so entries newer than the tick never count as old
   assign age     = {1'b0, now_ff} - {1'b0, rd_time};
   assign too_old = !age[TIME_BITS] && (age[TIME_BITS-1:0] > TIME_BITS'(limit_ff));

   // compare against the old extremes: a new extreme gives a zero move
   assign diff_low  = {1'b0, rd_price} - {1'b0, low_ff};
   assign diff_high = {1'b0, high_ff} - {1'b0, rd_price};
   assign fire_buy  = !diff_low[PRICE_BITS] && (diff_low[PRICE_BITS-1:0] > delta_ff);
   assign fire_sell = !diff_high[PRICE_BITS] && (diff_high[PRICE_BITS-1:0] > delta_ff);

   always_comb begin
      state_in      = state_ff;
      inst_in       = inst_ff;
      wsec_in       = wsec_ff;
      delta_in      = delta_ff;
      now_in        = now_ff;
      price_in      = price_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      latched_in    = latched_ff;
      rem_in        = rem_ff;
      iss_addr_in   = iss_addr_ff;
      dat_addr_in   = iss_addr_ff;
      evict_in      = evict_ff;
      pos_in        = pos_ff;
      match_in      = match_ff;
      match_addr_in = match_addr_ff;
      wr_ptr_in     = wr_ptr_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      res_fire_in   = res_fire_ff;
      res_sell_in   = res_sell_ff;
      res_drop_in   = res_drop_ff;
      rd_issue      = 1'b0;
      step_done     = 1'b0;
      dat_vld_in    = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_ptr_ff;
      ram_wr_data   = {now_ff, price_ff};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INSTRUMENT: inst_in  = csr_wdata[INSTR_BITS-1:0];
            CSR_WINDOW:     wsec_in  = csr_wdata[WSEC_BITS-1:0];
            CSR_TRIGGER:    delta_in = csr_wdata[PRICE_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_fire_in = 1'b0;
               res_sell_in = 1'b0;
               res_drop_in = 1'b0;
               now_in      = req_data.tick_time_ms;
               price_in    = req_data.last_price;
               limit_in    = LIMIT_W'(wsec_ff) * MS_PER_SEC;
               if (req_data.op == OP_REARM) begin
                  latched_in = 1'b0;
                  head_in    = '0;
                  count_in   = '0;
                  state_in   = ST_DONE;
               end else if (req_data.tick_instrument != inst_ff) begin
                  state_in = ST_DONE;
               end else begin
                  rem_in      = count_ff;
                  iss_addr_in = head_ff;
                  evict_in    = 1'b1;
                  pos_in      = '0;
                  match_in    = 1'b0;
                  state_in    = ST_FIND;
               end
            end
         end

         // evict the old prefix, then look for the insertion point
         ST_FIND: begin
            rd_issue  = (rem_ff != '0);
            ram_rd_en = rd_issue;
            if (rd_issue) begin
               rem_in      = rem_ff - CNT_W'(1);
               iss_addr_in = ring_inc(iss_addr_ff);
            end
            if (dat_vld_ff) begin
               if (evict_ff && too_old) begin
                  head_in  = ring_inc(head_ff);
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  evict_in = 1'b0;
                  if (rd_time < now_ff) begin
                     pos_in = pos_ff + CNT_W'(1);
                  end else begin
                     step_done     = 1'b1;
                     match_in      = (rd_time == now_ff);
                     match_addr_in = dat_addr_ff;
                  end
               end
            end else if (!rd_issue) begin
               step_done = 1'b1;
            end
            dat_vld_in = rd_issue && !step_done;
            if (step_done) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (match_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = match_addr_ff;
               if (latched_ff) begin
                  state_in = ST_DONE;
               end else begin
                  rem_in      = count_ff;
                  iss_addr_in = head_ff;
                  low_in      = '1;
                  high_in     = '0;
                  state_in    = ST_SCAN;
               end
            end else begin
               if (count_ff == DEPTH_C) begin
                  head_in     = ring_inc(head_ff);
                  count_in    = count_ff - CNT_W'(1);
                  pos_in      = (pos_ff != '0) ? pos_ff - CNT_W'(1) : pos_ff;
                  res_drop_in = 1'b1;
               end
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            wr_ptr_in   = ring_add(head_ff, count_ff);
            iss_addr_in = ring_dec(ring_add(head_ff, count_ff));
            rem_in      = count_ff - pos_ff;
            state_in    = ST_SHIFT;
         end

         // move the newer entries up by one, newest first
         ST_SHIFT: begin
            rd_issue   = (rem_ff != '0);
            ram_rd_en  = rd_issue;
            dat_vld_in = rd_issue;
            if (rd_issue) begin
               rem_in      = rem_ff - CNT_W'(1);
               iss_addr_in = ring_dec(iss_addr_ff);
            end
            if (dat_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               wr_ptr_in   = ring_dec(wr_ptr_ff);
            end else if (!rd_issue) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               if (latched_ff) begin
                  state_in = ST_DONE;
               end else begin
                  rem_in      = count_ff + CNT_W'(1);
                  iss_addr_in = head_ff;
                  low_in      = '1;
                  high_in     = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            rd_issue  = (rem_ff != '0);
            ram_rd_en = rd_issue;
            if (rd_issue) begin
               rem_in      = rem_ff - CNT_W'(1);
               iss_addr_in = ring_inc(iss_addr_ff);
            end
            if (dat_vld_ff) begin
               low_in  = diff_low[PRICE_BITS] ? rd_price : low_ff;
               high_in = diff_high[PRICE_BITS] ? rd_price : high_ff;
               if (fire_buy || fire_sell) begin
                  step_done   = 1'b1;
                  latched_in  = 1'b1;
                  res_fire_in = 1'b1;
                  res_sell_in = !fire_buy;
               end
            end else if (!rd_issue) begin
               step_done = 1'b1;
            end
            dat_vld_in = rd_issue && !step_done;
            if (step_done) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register parts the two sides
   always_comb begin
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.order_fire     = res_fire_ff;
         rsp_data_in.order_is_sell  = res_sell_ff;
         rsp_data_in.order_price    = res_fire_ff ? price_ff : '0;
         rsp_data_in.window_dropped = res_drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inst_ff      <= RST_INSTRUMENT;
         wsec_ff      <= RST_WINDOW;
         delta_ff     <= RST_TRIGGER;
         head_ff      <= '0;
         count_ff     <= '0;
         latched_ff   <= 1'b0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inst_ff      <= inst_in;
         wsec_ff      <= wsec_in;
         delta_ff     <= delta_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         latched_ff   <= latched_in;
         dat_vld_ff   <= dat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      price_ff      <= price_in;
      limit_ff      <= limit_in;
      rem_ff        <= rem_in;
      iss_addr_ff   <= iss_addr_in;
      dat_addr_ff   <= dat_addr_in;
      evict_ff      <= evict_in;
      pos_ff        <= pos_in;
      match_ff      <= match_in;
      match_addr_ff <= match_addr_in;
      wr_ptr_ff     <= wr_ptr_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      res_fire_ff   <= res_fire_in;
      res_sell_ff   <= res_sell_in;
      res_drop_ff   <= res_drop_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("window fill beyond depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start");

   a_fire_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_load && res_fire_ff |-> latched_ff)
      else $error("order result without latch");

   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ram_wr_addr <= LAST_IDX)
      else $error("window write outside ring");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PREP |-> pos_ff <= count_ff)
      else $error("insertion point past window fill");

endmodule
